// ----- hw/rtl/owrs_pkg.sv -----
`default_nettype none

package owrs_pkg;

    // Search geometry.
    localparam int CODE_BITS_DEF = 64;
    localparam int ROM_CODE_W    = 64;

    // Retry limit register.
    localparam int         RETRY_W         = 4;
    localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;

    // Register bus geometry: one 32-bit register at byte address zero.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_RETRY_LIMIT = '0;

    // Operation codes of an input word.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_PAIR  = 2'd2;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_BIT     = 3'd0,
        ST_FOUND   = 3'd1,
        ST_NOMORE  = 3'd2,
        ST_FAILED  = 3'd3,
        ST_ABORTED = 3'd4,
        ST_STARTED = 3'd5,
        ST_CLEARED = 3'd6,
        ST_IGNORED = 3'd7
    } status_t;

    typedef struct packed {
        logic [1:0] operation;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
    } item_t;

    typedef struct packed {
        logic                  direction_bit;
        status_t               status;
        logic [ROM_CODE_W-1:0] rom_code;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/owrs_if.sv -----
`default_nettype none

// Input channel: one command word per handshake.
interface owrs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;

    modport source (
        output valid, operation, presence, id_bit, complement_bit,
        input  ready
    );
    modport sink (
        input  valid, operation, presence, id_bit, complement_bit,
        output ready
    );
endinterface

// Output channel: one result word per handshake.
interface owrs_out_if;
    import owrs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  direction_bit;
    logic [2:0]            status;
    logic [ROM_CODE_W-1:0] rom_code;

    modport source (
        output valid, direction_bit, status, rom_code,
        input  ready
    );
    modport sink (
        input  valid, direction_bit, status, rom_code,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/owrs_apb_regs.sv -----
`default_nettype none

module owrs_apb_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [owrs_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [owrs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [owrs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output logic      [owrs_pkg::RETRY_W-1:0]     retry_limit
);
    import owrs_pkg::*;

    logic [RETRY_W-1:0]   retry_limit_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // Word address decode; the low two byte-address bits are ignored.
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // Retry limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_LIMIT_RST;
        end
        else if (wr_en && (reg_idx == REG_RETRY_LIMIT))
        begin
            retry_limit_reg <= pwdata[RETRY_W-1:0];
        end
    end

    // Read-back mux.
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_RETRY_LIMIT)
        begin
            prdata = APB_DATA_W'(retry_limit_reg);
        end
    end

    assign retry_limit = retry_limit_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/owrs_engine.sv -----
`default_nettype none

module owrs_engine #(
    parameter int CODE_BITS = owrs_pkg::CODE_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [owrs_pkg::RETRY_W-1:0] retry_limit,
    input  wire logic                         item_valid,
    input  wire owrs_pkg::item_t              item,
    output logic                              item_ready,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output owrs_pkg::result_t                 res
);
    import owrs_pkg::*;

    localparam int POS_W = $clog2(CODE_BITS + 1);
    localparam int IDX_W = $clog2(CODE_BITS);

    // Input register.
    item_t item_reg;
    logic  item_valid_reg;
    logic  item_valid_next;

    // Search state.
    logic [CODE_BITS-1:0] rom_bits_reg,   rom_bits_next;
    logic [POS_W-1:0]     last_disc_reg,  last_disc_next;
    logic                 last_dev_reg,   last_dev_next;
    logic [POS_W-1:0]     bit_pos_reg,    bit_pos_next;
    logic [POS_W-1:0]     last_zero_reg,  last_zero_next;
    logic [RETRY_W-1:0]   retry_cnt_reg,  retry_cnt_next;
    logic                 pass_act_reg,   pass_act_next;

    logic                 fire;
    logic                 in_take;
    logic [POS_W-1:0]     pos_m1;
    logic [IDX_W-1:0]     idx;
    logic                 chosen;
    logic [CODE_BITS-1:0] rom_upd;
    logic [POS_W-1:0]     zero_upd;
    logic [RETRY_W-1:0]   cnt_inc;

    // Handshake: the registered word moves on when the result stage takes it.
    assign fire       = item_valid_reg && res_ready;
    assign item_ready = !item_valid_reg || res_ready;
    assign in_take    = item_valid && item_ready;
    assign res_valid  = item_valid_reg;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= item;
        end
    end

    // Direction choice for the current position and the updated code.
    assign pos_m1  = bit_pos_reg - POS_W'(1);
    assign idx     = pos_m1[IDX_W-1:0];
    assign cnt_inc = retry_cnt_reg + RETRY_W'(1);

    always_comb
    begin
        zero_upd = last_zero_reg;
        if (item_reg.id_bit != item_reg.complement_bit)
        begin
            chosen = item_reg.id_bit;
        end
        else
        begin
            // Discrepancy: follow the previous pass below the last branch
            // point, take one at it and zero beyond it.
            if (bit_pos_reg == last_disc_reg)
            begin
                chosen = 1'b1;
            end
            else if (bit_pos_reg > last_disc_reg)
            begin
                chosen = 1'b0;
            end
            else
            begin
                chosen = rom_bits_reg[idx];
            end
            if (!chosen)
            begin
                zero_upd = bit_pos_reg;
            end
        end
        rom_upd      = rom_bits_reg;
        rom_upd[idx] = chosen;
    end

    // State update and result word.
    always_comb
    begin
        rom_bits_next  = rom_bits_reg;
        last_disc_next = last_disc_reg;
        last_dev_next  = last_dev_reg;
        bit_pos_next   = bit_pos_reg;
        last_zero_next = last_zero_reg;
        retry_cnt_next = retry_cnt_reg;
        pass_act_next  = pass_act_reg;

        res.direction_bit = 1'b0;
        res.status        = ST_IGNORED;
        res.rom_code      = '0;

        case (item_reg.operation)
            OP_CLEAR:
            begin
                rom_bits_next  = '0;
                last_disc_next = '0;
                last_dev_next  = 1'b0;
                bit_pos_next   = POS_W'(1);
                last_zero_next = '0;
                retry_cnt_next = '0;
                pass_act_next  = 1'b0;
                res.status     = ST_CLEARED;
            end
            OP_START:
            begin
                if (last_dev_reg)
                begin
                    pass_act_next  = 1'b0;
                    retry_cnt_next = '0;
                    res.status     = ST_NOMORE;
                end
                else if (!item_reg.presence)
                begin
                    // No device answered the reset: start the search over.
                    rom_bits_next  = '0;
                    last_disc_next = '0;
                    last_dev_next  = 1'b0;
                    bit_pos_next   = POS_W'(1);
                    last_zero_next = '0;
                    retry_cnt_next = '0;
                    pass_act_next  = 1'b0;
                    res.status     = ST_NOMORE;
                end
                else
                begin
                    pass_act_next  = 1'b1;
                    bit_pos_next   = POS_W'(1);
                    last_zero_next = '0;
                    res.status     = ST_STARTED;
                end
            end
            OP_PAIR:
            begin
                if (pass_act_reg)
                begin
                    if (item_reg.id_bit && item_reg.complement_bit)
                    begin
                        // Nobody answered the slot pair: abort this pass.
                        pass_act_next = 1'b0;
                        if (cnt_inc >= retry_limit)
                        begin
                            retry_cnt_next = '0;
                            res.status     = ST_FAILED;
                        end
                        else
                        begin
                            retry_cnt_next = cnt_inc;
                            res.status     = ST_ABORTED;
                        end
                    end
                    else
                    begin
                        rom_bits_next     = rom_upd;
                        last_zero_next    = zero_upd;
                        res.direction_bit = chosen;
                        if (bit_pos_reg >= POS_W'(CODE_BITS))
                        begin
                            // Last position: close the pass.
                            pass_act_next  = 1'b0;
                            retry_cnt_next = '0;
                            last_disc_next = zero_upd;
                            if (zero_upd == '0)
                            begin
                                last_dev_next = 1'b1;
                            end
                            if (rom_upd == '0)
                            begin
                                rom_bits_next  = '0;
                                last_disc_next = '0;
                                last_dev_next  = 1'b0;
                                bit_pos_next   = POS_W'(1);
                                last_zero_next = '0;
                                res.status     = ST_NOMORE;
                            end
                            else
                            begin
                                res.rom_code = ROM_CODE_W'(rom_upd);
                                res.status   = ST_FOUND;
                            end
                        end
                        else
                        begin
                            bit_pos_next = bit_pos_reg + POS_W'(1);
                            res.status   = ST_BIT;
                        end
                    end
                end
            end
            default:
            begin
                res.status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bits_reg  <= '0;
            last_disc_reg <= '0;
            last_dev_reg  <= 1'b0;
            bit_pos_reg   <= POS_W'(1);
            last_zero_reg <= '0;
            retry_cnt_reg <= '0;
            pass_act_reg  <= 1'b0;
        end
        else if (fire)
        begin
            rom_bits_reg  <= rom_bits_next;
            last_disc_reg <= last_disc_next;
            last_dev_reg  <= last_dev_next;
            bit_pos_reg   <= bit_pos_next;
            last_zero_reg <= last_zero_next;
            retry_cnt_reg <= retry_cnt_next;
            pass_act_reg  <= pass_act_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/owrs_result_reg.sv -----
`default_nettype none

module owrs_result_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              res_valid,
    output logic                   res_ready,
    input  wire owrs_pkg::result_t res,
    owrs_out_if.source             out_ch
);
    import owrs_pkg::*;

    result_t res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    load;

    // The register takes a new word when empty or when its word leaves.
    assign res_ready = !out_valid_reg || out_ch.ready;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    // Output channel drive.
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.direction_bit = res_reg.direction_bit;
    assign out_ch.status        = res_reg.status;
    assign out_ch.rom_code      = res_reg.rom_code;

endmodule

`default_nettype wire

// ----- hw/rtl/one_wire_rom_search_engine_core.sv -----
`default_nettype none

// Decision engine for a 1-Wire ROM search. The host runs the bus slots and
// sends one command word per step: clear the search, start a pass with the
// presence result of the bus reset, or hand over the id bit and complement
// bit sampled at the current position. For every command the core returns
// exactly one result word: the direction bit to write back for a bit pair,
// a status code, and the 64-bit ROM code (position one in bit zero) when a
// pass ends with a device found. A pair of two ones aborts the pass; once
// the number of aborted passes reaches the retry limit register (byte
// address 0, reset value 3) the status reports failure. The core accepts a
// word in every clock cycle unless the output side stalls; the word passes
// an input register and then an output register, and the decision for a
// bit pair and the update of the search state are worked out between
// them. Write the retry limit only while no word is in flight.
module one_wire_rom_search_engine_core #(
    parameter int CODE_BITS = owrs_pkg::CODE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [owrs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [owrs_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [owrs_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    owrs_in_if.sink                              in_ch,
    owrs_out_if.source                           out_ch
);
    import owrs_pkg::*;

    logic [RETRY_W-1:0] retry_limit;
    item_t              item;
    logic               item_ready;
    logic               res_valid;
    logic               res_ready;
    result_t            res;

    // Input word packing.
    assign item.operation      = in_ch.operation;
    assign item.presence       = in_ch.presence;
    assign item.id_bit         = in_ch.id_bit;
    assign item.complement_bit = in_ch.complement_bit;
    assign in_ch.ready         = item_ready;

    owrs_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .retry_limit (retry_limit)
    );

    owrs_engine #(
        .CODE_BITS (CODE_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .retry_limit (retry_limit),
        .item_valid  (in_ch.valid),
        .item        (item),
        .item_ready  (item_ready),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    owrs_result_reg u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

// ----- dv/one_wire_rom_search_engine_core_tb.sv -----
`timescale 1ns / 1ps

module one_wire_rom_search_engine_core_tb;
    import owrs_pkg::*;

    // The fourth operation code has no meaning and must be ignored.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Fixed results that can be read off directly in the directed table.
    localparam result_t R_MODEL   = '0;
    localparam result_t R_IGNORED = '{1'b0, ST_IGNORED, 64'd0};
    localparam result_t R_NOMORE  = '{1'b0, ST_NOMORE, 64'd0};
    localparam result_t R_CLEARED = '{1'b0, ST_CLEARED, 64'd0};
    localparam result_t R_STARTED = '{1'b0, ST_STARTED, 64'd0};
    localparam result_t R_ABORTED = '{1'b0, ST_ABORTED, 64'd0};
    localparam result_t R_FAILED  = '{1'b0, ST_FAILED, 64'd0};

    typedef struct packed {
        item_t   word;
        logic    typed;
        result_t want;
    } vector_t;

    // Directed words, run at the reset retry limit of three.
    localparam int N_DIRECTED = 22;
    localparam vector_t DIRECTED [N_DIRECTED] = '{
        '{'{OP_PAIR,   1'b0, 1'b1, 1'b0}, 1'b1, R_IGNORED},
        '{'{OP_UNUSED, 1'b1, 1'b1, 1'b1}, 1'b1, R_IGNORED},
        '{'{OP_START,  1'b0, 1'b0, 1'b0}, 1'b1, R_NOMORE},
        '{'{OP_CLEAR,  1'b1, 1'b1, 1'b1}, 1'b1, R_CLEARED},
        '{'{OP_START,  1'b1, 1'b0, 1'b1}, 1'b1, R_STARTED},
        '{'{OP_PAIR,   1'b0, 1'b1, 1'b1}, 1'b1, R_ABORTED},
        '{'{OP_START,  1'b1, 1'b1, 1'b0}, 1'b1, R_STARTED},
        '{'{OP_PAIR,   1'b1, 1'b1, 1'b1}, 1'b1, R_ABORTED},
        '{'{OP_START,  1'b1, 1'b1, 1'b1}, 1'b1, R_STARTED},
        '{'{OP_PAIR,   1'b0, 1'b1, 1'b1}, 1'b1, R_FAILED},
        '{'{OP_START,  1'b1, 1'b0, 1'b0}, 1'b1, R_STARTED},
        '{'{OP_PAIR,   1'b0, 1'b0, 1'b0}, 1'b0, R_MODEL},
        '{'{OP_PAIR,   1'b1, 1'b0, 1'b1}, 1'b0, R_MODEL},
        '{'{OP_PAIR,   1'b0, 1'b1, 1'b0}, 1'b0, R_MODEL},
        '{'{OP_START,  1'b1, 1'b0, 1'b0}, 1'b1, R_STARTED},
        '{'{OP_PAIR,   1'b0, 1'b0, 1'b0}, 1'b0, R_MODEL},
        '{'{OP_PAIR,   1'b0, 1'b1, 1'b1}, 1'b1, R_ABORTED},
        '{'{OP_PAIR,   1'b0, 1'b0, 1'b1}, 1'b1, R_IGNORED},
        '{'{OP_START,  1'b1, 1'b1, 1'b0}, 1'b0, R_MODEL},
        '{'{OP_PAIR,   1'b1, 1'b1, 1'b0}, 1'b0, R_MODEL},
        '{'{OP_CLEAR,  1'b0, 1'b0, 1'b0}, 1'b1, R_CLEARED},
        '{'{OP_PAIR,   1'b1, 1'b0, 1'b0}, 1'b1, R_IGNORED}
    };

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    owrs_in_if  in_ch ();
    owrs_out_if out_ch ();

    one_wire_rom_search_engine_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #1 clk = ~clk;

    // Search state as the engine should hold it.
    logic [63:0]  code_reg;
    logic [6:0]   last_disc;
    logic         last_dev;
    logic [6:0]   cur_pos;
    logic [6:0]   zero_pos;
    logic [3:0]   aborts;
    logic         in_pass;
    logic [3:0]   limit_reg;

    result_t      expected_q [$];
    result_t      head;
    int           mismatches = 0;
    int           words_sent = 0;
    bit           steady = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got_v, want_v,
                 $realtime);
        mismatches++;
    endtask

    function automatic logic coin();
        return $urandom_range(0, 1) != 0;
    endfunction

    function automatic void clear_search();
        code_reg  = '0;
        last_disc = '0;
        last_dev  = 1'b0;
        cur_pos   = 7'd1;
        zero_pos  = '0;
        aborts    = '0;
        in_pass   = 1'b0;
    endfunction

    // Advance the search state by one word and return the result it causes.
    function automatic result_t search_step(input item_t w);
        result_t    r;
        logic [6:0] pos;
        logic [5:0] idx;
        logic       chosen;
        r = R_IGNORED;
        if (w.operation == OP_CLEAR) begin
            clear_search();
            r.status = ST_CLEARED;
        end else if (w.operation == OP_START) begin
            if (last_dev) begin
                in_pass  = 1'b0;
                aborts   = '0;
                r.status = ST_NOMORE;
            end else if (!w.presence) begin
                clear_search();
                r.status = ST_NOMORE;
            end else begin
                in_pass  = 1'b1;
                cur_pos  = 7'd1;
                zero_pos = '0;
                r.status = ST_STARTED;
            end
        end else if (w.operation == OP_PAIR && in_pass) begin
            if (w.id_bit && w.complement_bit) begin
                // No device answered: the pass is lost and counts as an abort.
                in_pass = 1'b0;
                aborts  = aborts + 4'd1;
                if (aborts >= limit_reg) begin
                    aborts   = '0;
                    r.status = ST_FAILED;
                end else begin
                    r.status = ST_ABORTED;
                end
            end else begin
                pos = cur_pos;
                idx = 6'(pos - 7'd1);
                if (w.id_bit != w.complement_bit) begin
                    chosen = w.id_bit;
                end else begin
                    // Discrepancy: follow the search tree from the last pass.
                    if (pos == last_disc)
                        chosen = 1'b1;
                    else if (pos > last_disc)
                        chosen = 1'b0;
                    else
                        chosen = code_reg[idx];
                    if (!chosen)
                        zero_pos = pos;
                end
                code_reg[idx]   = chosen;
                r.direction_bit = chosen;
                if (pos >= 7'(CODE_BITS_DEF)) begin
                    in_pass   = 1'b0;
                    aborts    = '0;
                    last_disc = zero_pos;
                    if (last_disc == '0)
                        last_dev = 1'b1;
                    if (code_reg == '0) begin
                        clear_search();
                        r.status = ST_NOMORE;
                    end else begin
                        r.rom_code = code_reg;
                        r.status   = ST_FOUND;
                    end
                end else begin
                    cur_pos  = pos + 7'd1;
                    r.status = ST_BIT;
                end
            end
        end
        return r;
    endfunction

    // Offer one word, with random idle cycles ahead of it outside the steady stretch, and wait until it is taken.
    task automatic send_word(input item_t w, input logic typed, input result_t fixed,
                             output result_t want);
        while (!steady && $urandom_range(0, 99) < 37) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.operation      <= w.operation;
        in_ch.presence       <= w.presence;
        in_ch.id_bit         <= w.id_bit;
        in_ch.complement_bit <= w.complement_bit;
        want = search_step(w);
        if (typed)
            want = fixed;
        expected_q = {expected_q, want};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_op(input logic [1:0] op, input logic pres, input logic idb,
                           input logic cmpb, output result_t want);
        send_word('{op, pres, idb, cmpb}, 1'b0, R_MODEL, want);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Register access: setup cycle, then access cycle.
    task automatic apb_access(input logic wr, input logic [3:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_RETRY_LIMIT, 2'b00};
        pwdata  <= APB_DATA_W'(wdata);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_retry_limit(input logic [3:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, value, rd);
        limit_reg = value;
        // The bus idles between the write and the read-back.
        @(posedge clk);
        apb_access(1'b0, 4'd0, rd);
        if (rd[RETRY_W-1:0] !== value)
            report_mismatch("retry_limit readback", 64'(rd[RETRY_W-1:0]), 64'(value));
    endtask

    // A population of devices on the bus answers each slot as a wired AND.
    task automatic search_population(input int count, input logic [63:0] first_code);
        logic [63:0] devs [4];
        logic [3:0]  alive;
        logic        idv;
        logic        cmpv;
        result_t     got;
        int          passes;
        bit          done;
        devs[0] = first_code;
        for (int k = 1; k < count; k++)
            devs[k] = coin() ? {$urandom, $urandom}
                             : first_code ^ (64'd1 << $urandom_range(0, 63))
                                          ^ (64'd1 << $urandom_range(0, 63));
        send_op(OP_CLEAR, coin(), coin(), coin(), got);
        done   = 1'b0;
        passes = 0;
        while (!done && passes < count + 4) begin
            passes++;
            send_op(OP_START, $urandom_range(0, 29) != 0, coin(), coin(), got);
            if (got.status != ST_STARTED) begin
                done = 1'b1;
            end else begin
                alive = 4'((5'd1 << count) - 5'd1);
                for (int p = 0; p < CODE_BITS_DEF; p++) begin
                    // Now and then the host restarts the pass in the middle.
                    if ($urandom_range(0, 399) == 0)
                        break;
                    idv  = 1'b1;
                    cmpv = 1'b1;
                    for (int d = 0; d < count; d++) begin
                        if (alive[d]) begin
                            idv  = idv & devs[d][p];
                            cmpv = cmpv & ~devs[d][p];
                        end
                    end
                    // A rare bus glitch reads as no device at all.
                    if ($urandom_range(0, 399) == 0) begin
                        idv  = 1'b1;
                        cmpv = 1'b1;
                    end
                    send_op(OP_PAIR, coin(), idv, cmpv, got);
                    if (got.status != ST_BIT)
                        break;
                    for (int d = 0; d < count; d++)
                        if (devs[d][p] != got.direction_bit)
                            alive[d] = 1'b0;
                end
                if (got.status == ST_NOMORE)
                    done = 1'b1;
            end
        end
    endtask

    task automatic abort_run(input int n);
        result_t got;
        if (coin())
            send_op(OP_CLEAR, coin(), coin(), coin(), got);
        for (int k = 0; k < n; k++) begin
            send_op(OP_START, 1'b1, coin(), coin(), got);
            send_op(OP_PAIR, coin(), 1'b1, 1'b1, got);
        end
    endtask

    task automatic random_words(input int n);
        result_t got;
        for (int k = 0; k < n; k++)
            send_op(2'($urandom_range(0, 3)), coin(), coin(), coin(), got);
    endtask

    // Result side: random stalls, except during the steady stretch.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_ch.ready <= steady || ($urandom_range(0, 99) >= 37);
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected", 64'(out_ch.status), 64'd0);
            end else begin
                head = expected_q.pop_front();
                if (out_ch.direction_bit !== head.direction_bit)
                    report_mismatch("direction_bit", 64'(out_ch.direction_bit),
                                    64'(head.direction_bit));
                if (out_ch.status !== head.status)
                    report_mismatch("status", 64'(out_ch.status), 64'(head.status));
                if (out_ch.rom_code !== head.rom_code)
                    report_mismatch("rom_code", out_ch.rom_code, head.rom_code);
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [3:0]            phase_limits [4];
        logic [APB_DATA_W-1:0] rd;
        result_t               got;
        int                    phase_start;
        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.operation      <= OP_CLEAR;
        in_ch.presence       <= 1'b0;
        in_ch.id_bit         <= 1'b0;
        in_ch.complement_bit <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        clear_search();
        limit_reg = RETRY_LIMIT_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The register must come out of reset at its documented value.
        apb_access(1'b0, 4'd0, rd);
        if (rd[RETRY_W-1:0] !== RETRY_LIMIT_RST)
            report_mismatch("retry_limit after reset", 64'(rd[RETRY_W-1:0]),
                            64'(RETRY_LIMIT_RST));

        for (int i = 0; i < N_DIRECTED; i++)
            send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want, got);

        // Random phases: a limit of zero, both extremes and one value between.
        phase_limits[0] = 4'd0;
        phase_limits[1] = 4'd1;
        phase_limits[2] = 4'd15;
        phase_limits[3] = 4'($urandom_range(2, 14));
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            set_retry_limit(phase_limits[ph]);
            steady      = (ph == 2);
            phase_start = words_sent;
            if (ph == 0)
                search_population(1, 64'd0);
            else if (ph == 1)
                search_population(1, '1);
            while (words_sent - phase_start < 80) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: search_population($urandom_range(1, 3),
                                                        {$urandom, $urandom});
                    6, 7:             abort_run($urandom_range(1, 16));
                    default:          random_words($urandom_range(3, 12));
                endcase
            end
        end
        steady = 1'b0;

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/owrs_pkg.sv
hw/rtl/owrs_if.sv
hw/rtl/owrs_apb_regs.sv
hw/rtl/owrs_engine.sv
hw/rtl/owrs_result_reg.sv
hw/rtl/one_wire_rom_search_engine_core.sv
dv/one_wire_rom_search_engine_core_tb.sv
